FILE: hdl/tftpc_pkg.sv
// shared types and codes for the tftp client transfer control
`default_nettype none

package tftpc_pkg;

  // input event opcodes
  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_ACK   = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_OTHER = 3'd3;
  localparam logic [2:0] OP_TOUT  = 3'd4;
  localparam logic [2:0] OP_INTR  = 3'd5;
  localparam logic [2:0] OP_CHUNK = 3'd6;

  // result actions
  localparam logic [2:0] ACT_WRQ   = 3'd0;
  localparam logic [2:0] ACT_RRQ   = 3'd1;
  localparam logic [2:0] ACT_DATA  = 3'd2;
  localparam logic [2:0] ACT_ACK   = 3'd3;
  localparam logic [2:0] ACT_ERROR = 3'd4;
  localparam logic [2:0] ACT_REQ   = 3'd5;
  localparam logic [2:0] ACT_WRITE = 3'd6;
  localparam logic [2:0] ACT_FIN   = 3'd7;

  // error kinds
  localparam logic ERR_NOT_DEFINED = 1'b0;
  localparam logic ERR_ILLEGAL     = 1'b1;

  // configuration register indexes
  localparam logic CFG_MODE_SEND  = 1'b0;
  localparam logic CFG_BLOCK_SIZE = 1'b1;

  localparam logic [15:0] BLOCK_SIZE_RESET = 16'd512;
  localparam logic [16:0] BLOCK_LIMIT      = 17'd65535;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] block_number;
    logic [15:0] length;
  } evt_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] block_out;
    logic [15:0] length_out;
    logic        error_kind;
    logic        transfer_ok;
    logic        last_of_run;
  } res_t;

  // results caused by one event, oldest in slot 0
  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      r;
  } bundle_t;

  function automatic res_t mk_res(logic [2:0] act, logic [15:0] blk, logic [15:0] len,
                                  logic ek, logic ok);
    res_t t;
    t.action      = act;
    t.block_out   = blk;
    t.length_out  = len;
    t.error_kind  = ek;
    t.transfer_ok = ok;
    t.last_of_run = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tftpc_stream_if.sv
// valid/ready channel carrying one payload per beat
`default_nettype none

interface tftpc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tftp_client_transfer_control.sv
// tftp client transfer control: event decision and result queue
//
//  channel  dir  payload                                         handshake
//  evt      in   opcode, block_number, length                    valid/ready
//  res      out  action, block_out, length_out, error_kind,      valid/ready
//                transfer_ok, last_of_run
//  cfg      in   cfg_we, cfg_index, cfg_data                     write only
//
// each event is decided in the cycle it is taken; its results, up to three, are
// registered as a bundle (held in the skid bundle while the output bundle is busy)
// and leave one per beat. one event per cycle while every event yields one result
// and res is taken.
// a second bundle register lets evt take a beat while res is stalled; evt
// ready drops only when both bundle registers are full.
// synchronous active-high reset clears the transfer state and both bundles.
`default_nettype none

module tftp_client_transfer_control (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  tftpc_stream_if.sink     evt,
  tftpc_stream_if.source   res
);

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_FIRST_SEND = 3'd1;
  localparam logic [2:0] PH_FIRST_RECV = 3'd2;
  localparam logic [2:0] PH_NEED_CHUNK = 3'd3;
  localparam logic [2:0] PH_WAIT_ACK   = 3'd4;
  localparam logic [2:0] PH_WAIT_DATA  = 3'd5;

  logic        mode_send;
  logic [15:0] block_size;

  logic [2:0]  phase, phase_next;
  logic [16:0] block_counter, block_counter_next;
  logic [15:0] chunk_length, chunk_length_next;
  logic        reply_seen, reply_seen_next;

  tftpc_pkg::bundle_t ob, sb, nb;
  logic               push, pop, ob_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_send  <= 1'b0;
      block_size <= tftpc_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tftpc_pkg::CFG_MODE_SEND:  mode_send  <= cfg_data[0];
        tftpc_pkg::CFG_BLOCK_SIZE: block_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // event decision
  always_comb begin
    logic [2:0]  op;
    logic [16:0] blk;
    logic [15:0] len;
    logic [16:0] cnt_inc;
    logic        ack_ok;
    logic        data_ok;
    logic        intr;
    logic        fail_ill;
    logic        fail_nd;
    logic        fin_ok;
    logic        fin_fail;
    logic [1:0]  k;
    op      = evt.data.opcode;
    blk     = {1'b0, evt.data.block_number};
    len     = evt.data.length;
    cnt_inc = block_counter + 17'd1;
    ack_ok  = (phase == PH_FIRST_SEND) || (phase == PH_WAIT_ACK);
    data_ok = (phase == PH_FIRST_RECV) || (phase == PH_WAIT_DATA);
    intr     = 1'b0;
    fail_ill = 1'b0;
    fail_nd  = 1'b0;
    fin_ok   = 1'b0;
    fin_fail = 1'b0;
    k        = 2'd0;

    phase_next         = phase;
    block_counter_next = block_counter;
    chunk_length_next  = chunk_length;
    reply_seen_next    = reply_seen;
    nb                 = '0;

    case (phase)
      PH_IDLE: begin
        if (op == tftpc_pkg::OP_START) begin
          block_counter_next = 17'd1;
          chunk_length_next  = 16'd0;
          reply_seen_next    = 1'b0;
          if (mode_send) begin
            nb.r[0]    = tftpc_pkg::mk_res(tftpc_pkg::ACT_WRQ, 16'd0, 16'd0, 1'b0, 1'b0);
            phase_next = PH_FIRST_SEND;
          end else begin
            nb.r[0]    = tftpc_pkg::mk_res(tftpc_pkg::ACT_RRQ, 16'd0, 16'd0, 1'b0, 1'b0);
            phase_next = PH_FIRST_RECV;
          end
          k = 2'd1;
        end
      end
      PH_FIRST_SEND, PH_FIRST_RECV, PH_WAIT_ACK, PH_WAIT_DATA: begin
        if (op == tftpc_pkg::OP_ACK || op == tftpc_pkg::OP_DATA ||
            op == tftpc_pkg::OP_OTHER) begin
          reply_seen_next = 1'b1;
          if (ack_ok && op == tftpc_pkg::OP_ACK) begin
            if (phase == PH_FIRST_SEND) begin
              nb.r[0]    = tftpc_pkg::mk_res(tftpc_pkg::ACT_REQ, 16'd0, 16'd0, 1'b0, 1'b0);
              k          = 2'd1;
              phase_next = PH_NEED_CHUNK;
            end else if (blk == block_counter) begin
              block_counter_next = cnt_inc;
              if (chunk_length < block_size) begin
                fin_ok = 1'b1;
              end else begin
                nb.r[0]    = tftpc_pkg::mk_res(tftpc_pkg::ACT_REQ, 16'd0, 16'd0, 1'b0, 1'b0);
                k          = 2'd1;
                phase_next = PH_NEED_CHUNK;
              end
            end else if (blk > block_counter) begin
              fail_ill = 1'b1;
            end else begin
              // old ack: resend the block in flight
              nb.r[0] = tftpc_pkg::mk_res(tftpc_pkg::ACT_DATA, block_counter[15:0],
                                          chunk_length, 1'b0, 1'b0);
              k       = 2'd1;
            end
          end else if (data_ok && op == tftpc_pkg::OP_DATA) begin
            if (len > block_size) begin
              fail_nd = 1'b1;
            end else if (blk > block_counter) begin
              fail_ill = 1'b1;
            end else begin
              if (blk == block_counter) begin
                nb.r[0] = tftpc_pkg::mk_res(tftpc_pkg::ACT_WRITE, 16'd0, len, 1'b0, 1'b0);
                nb.r[1] = tftpc_pkg::mk_res(tftpc_pkg::ACT_ACK, block_counter[15:0],
                                            16'd0, 1'b0, 1'b0);
                block_counter_next = cnt_inc;
                k = 2'd2;
              end else begin
                // duplicate block: acknowledge again
                nb.r[0] = tftpc_pkg::mk_res(tftpc_pkg::ACT_ACK, block_counter[15:0] - 16'd1,
                                            16'd0, 1'b0, 1'b0);
                k = 2'd1;
              end
              if (len < block_size) begin
                fin_ok = 1'b1;
              end else begin
                phase_next = PH_WAIT_DATA;
              end
            end
          end else begin
            fail_ill = 1'b1;
          end
        end else if (op == tftpc_pkg::OP_TOUT) begin
          fin_fail = 1'b1;
        end else if (op == tftpc_pkg::OP_INTR) begin
          intr = 1'b1;
        end
      end
      PH_NEED_CHUNK: begin
        if (op == tftpc_pkg::OP_CHUNK) begin
          if (block_counter == tftpc_pkg::BLOCK_LIMIT) begin
            fail_nd = 1'b1;
          end else begin
            chunk_length_next = (len > block_size) ? block_size : len;
            nb.r[0]    = tftpc_pkg::mk_res(tftpc_pkg::ACT_DATA, block_counter[15:0],
                                           chunk_length_next, 1'b0, 1'b0);
            k          = 2'd1;
            phase_next = PH_WAIT_ACK;
          end
        end else if (op == tftpc_pkg::OP_INTR) begin
          intr = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // interrupt sends an error only once the peer has answered
    if (intr) begin
      if (reply_seen) begin
        fail_nd = 1'b1;
      end else begin
        fin_fail = 1'b1;
      end
    end

    // error then failed finish
    if (fail_ill || fail_nd) begin
      nb.r[0]  = tftpc_pkg::mk_res(tftpc_pkg::ACT_ERROR, 16'd0, 16'd0,
                                   fail_ill ? tftpc_pkg::ERR_ILLEGAL
                                            : tftpc_pkg::ERR_NOT_DEFINED, 1'b0);
      k        = 2'd1;
      fin_fail = 1'b1;
    end

    // closing finished result
    if (fin_ok || fin_fail) begin
      nb.r[k]    = tftpc_pkg::mk_res(tftpc_pkg::ACT_FIN, 16'd0, 16'd0, 1'b0, fin_ok);
      k          = k + 2'd1;
      phase_next = PH_IDLE;
    end

    nb.n = k;
    if (k != 2'd0) begin
      nb.r[k - 2'd1].last_of_run = 1'b1;
    end
  end

  // transfer state, advanced on every event beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      block_counter <= 17'd1;
      chunk_length  <= 16'd0;
      reply_seen    <= 1'b0;
    end else if (evt.valid && evt.ready) begin
      phase         <= phase_next;
      block_counter <= block_counter_next;
      chunk_length  <= chunk_length_next;
      reply_seen    <= reply_seen_next;
    end
  end

  // bundle queue: output bundle and skid bundle
  assign evt.ready = (sb.n == 2'd0);
  assign push      = evt.valid && evt.ready && (nb.n != 2'd0);
  assign pop       = res.valid && res.ready;
  assign ob_free   = (ob.n == 2'd0) || (pop && ob.n == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob.n <= 2'd0;
      sb.n <= 2'd0;
    end else if (ob_free) begin
      if (sb.n != 2'd0) begin
        ob   <= sb;
        sb.n <= 2'd0;
      end else if (push) begin
        ob <= nb;
      end else begin
        ob.n <= 2'd0;
      end
    end else begin
      if (pop) begin
        ob.n    <= ob.n - 2'd1;
        ob.r[0] <= ob.r[1];
        ob.r[1] <= ob.r[2];
      end
      if (push) begin
        sb <= nb;
      end
    end
  end

  assign res.valid = (ob.n != 2'd0);
  assign res.data  = ob.r[0];

endmodule

`default_nettype wire

FILE: hdl/tftpc_check.sv
// port checks for the tftp client transfer control and their binding
`default_nettype none

module tftpc_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [2:0]  action,
  input wire logic        transfer_ok,
  input wire logic        last_of_run,
  input wire logic [37:0] res_data
);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // nothing shown the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid straight after reset");

  // finished always closes the run of results
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == tftpc_pkg::ACT_FIN |-> last_of_run)
    else $error("finished result not last of its run");

  // an error is always followed by finished
  a_err_not_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == tftpc_pkg::ACT_ERROR |-> !last_of_run)
    else $error("error result ends its run");

  // success flag only on finished
  a_ok_on_fin: assert property (@(posedge clk) disable iff (rst)
    res_valid && transfer_ok |-> action == tftpc_pkg::ACT_FIN)
    else $error("transfer_ok set on a result that is not finished");

endmodule

bind tftp_client_transfer_control tftpc_check u_tftpc_check (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .action      (res.data.action),
  .transfer_ok (res.data.transfer_ok),
  .last_of_run (res.data.last_of_run),
  .res_data    (res.data)
);

`default_nettype wire
